[hw/rtl/zrle_pkg.sv]
// Shared types and constants for the zero run-length encoder.
`timescale 1ns / 1ps
`default_nettype none

package zrle_pkg;

  // Sizes the run counter; zero runs saturate at one less than this value.
  localparam int MAX_ITEMS_DEF = 4096;

  // Entries in the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Byte values that the encoding uses.
  localparam logic [7:0] BYTE_ZERO    = 8'd0;
  localparam logic [7:0] BYTE_RUN_MAX = 8'd255;
  localparam logic [7:0] BYTE_FIX_HI  = 8'd200;
  localparam logic [7:0] BYTE_FIX_LO  = 8'd55;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
  } out_item_t;

endpackage : zrle_pkg

`default_nettype wire

[hw/rtl/zrle_fifo.sv]
// Small command queue that decouples the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module zrle_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : zrle_fifo

`default_nettype wire

[hw/rtl/zrle_front.sv]
// Front part: accepts items, counts zero runs and issues commands.
`timescale 1ns / 1ps
`default_nettype none

module zrle_front
  import zrle_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int CNT_W     = $clog2(MAX_ITEMS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  input  logic             q_full,
  output logic             q_push,
  output logic [7:0]       cmd_data,
  output logic             cmd_last,
  output logic [CNT_W-1:0] cmd_run
);

  logic [CNT_W-1:0] run_r, run_nxt;
  logic             accept;
  logic             is_zero;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_zero  = (in_item.data_byte == BYTE_ZERO);

  // A zero byte that does not close the stream only bumps the counter.
  assign q_push   = accept && (!is_zero || in_item.last_item);
  assign cmd_data = in_item.data_byte;
  assign cmd_last = in_item.last_item;
  assign cmd_run  = is_zero ? '0 : run_r;

  always_comb begin
    run_nxt = run_r;
    if (accept) begin
      if (in_item.last_item || !is_zero) begin
        run_nxt = '0;
      end else if (run_r < CNT_W'(MAX_ITEMS - 1)) begin
        run_nxt = run_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule : zrle_front

`default_nettype wire

[hw/rtl/zrle_back.sv]
// Back part: expands one command into its encoded bytes.
`timescale 1ns / 1ps
`default_nettype none

module zrle_back
  import zrle_pkg::*;
#(
  parameter int CNT_W = $clog2(MAX_ITEMS_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic [7:0]       cmd_data,
  input  logic             cmd_last,
  input  logic [CNT_W-1:0] cmd_run,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  // The remainder is compared against 255, so it is never narrower than 9 bits.
  localparam int REM_W = (CNT_W > 9) ? CNT_W : 9;

  localparam logic [2:0] PH_MARK  = 3'd0;
  localparam logic [2:0] PH_RUN   = 3'd1;
  localparam logic [2:0] PH_FIX0  = 3'd2;
  localparam logic [2:0] PH_FIX55 = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_TERM0 = 3'd5;
  localparam logic [2:0] PH_TERM1 = 3'd6;

  logic             busy_r, busy_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        oitem_r, oitem_nxt;
  logic             can_emit;

  assign can_emit  = !ovalid_r || !out_stall;
  assign q_pop     = !busy_r && !q_empty;
  assign out_valid = ovalid_r;
  assign out_item  = oitem_r;

  always_comb begin
    busy_nxt   = busy_r;
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    data_nxt   = data_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r && out_stall;
    oitem_nxt  = oitem_r;

    if (!busy_r) begin
      if (!q_empty) begin
        busy_nxt = 1'b1;
        rem_nxt  = REM_W'(cmd_run);
        data_nxt = cmd_data;
        last_nxt = cmd_last;
        if (cmd_run != '0) begin
          phase_nxt = PH_MARK;
        end else if (cmd_data != BYTE_ZERO) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_TERM0;
        end
      end
    end else if (can_emit) begin
      ovalid_nxt              = 1'b1;
      oitem_nxt.last_of_run   = 1'b0;
      oitem_nxt.end_of_stream = 1'b0;
      oitem_nxt.out_byte      = BYTE_ZERO;
      unique case (phase_r)
        PH_MARK: begin
          phase_nxt = PH_RUN;
        end
        PH_RUN: begin
          if (rem_r > REM_W'(255)) begin
            oitem_nxt.out_byte = BYTE_RUN_MAX;
            rem_nxt            = rem_r - REM_W'(255);
          end else if (rem_r == REM_W'(255)) begin
            // A remainder of exactly 255 goes out as 200, 0, 55.
            oitem_nxt.out_byte = BYTE_FIX_HI;
            phase_nxt          = PH_FIX0;
          end else begin
            oitem_nxt.out_byte = rem_r[7:0];
            phase_nxt          = PH_DATA;
          end
        end
        PH_FIX0: begin
          phase_nxt = PH_FIX55;
        end
        PH_FIX55: begin
          oitem_nxt.out_byte = BYTE_FIX_LO;
          phase_nxt          = PH_DATA;
        end
        PH_DATA: begin
          oitem_nxt.out_byte = data_r;
          if (last_r) begin
            phase_nxt = PH_TERM0;
          end else begin
            oitem_nxt.last_of_run = 1'b1;
            busy_nxt              = 1'b0;
          end
        end
        PH_TERM0: begin
          phase_nxt = PH_TERM1;
        end
        PH_TERM1: begin
          oitem_nxt.last_of_run   = 1'b1;
          oitem_nxt.end_of_stream = 1'b1;
          busy_nxt                = 1'b0;
        end
        default: begin
          busy_nxt   = 1'b0;
          ovalid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= PH_MARK;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    data_r  <= data_nxt;
    last_r  <= last_nxt;
    oitem_r <= oitem_nxt;
  end

endmodule : zrle_back

`default_nettype wire

[hw/rtl/zero_run_length_encoder_core.sv]
// Top level of the zero run-length encoder: front part, command queue, back part.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+--------------------------------------
//   in_     | input     | in_valid/in_stall | in_item_t  {data_byte, last_item}
//   out_    | output    | out_valid/out_stall | out_item_t {out_byte, last_of_run,
//           |           |                   |             end_of_stream}
//
// A zero byte that does not end the stream is absorbed by the front part and produces
// no item. Any other item is queued as a command; the back part loads it and then
// produces its result items (up to 22) one after another, holding while the output
// stalls and taking no new command until the last is out, so it sets the throughput.
// The two-entry command queue lets the front keep counting zeros while the back works.
// Reset is synchronous and active low; it clears the run counter, the queue and the
// output register. A stall on the output holds the current result item in place and,
// once the queue fills, raises in_stall.
`timescale 1ns / 1ps
`default_nettype none

module zero_run_length_encoder_core
  import zrle_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // The run counter saturates at MAX_ITEMS-1.
  localparam int CNT_W = $clog2(MAX_ITEMS);
  localparam int CMD_W = 8 + 1 + CNT_W;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [7:0]       f_data;
  logic             f_last;
  logic [CNT_W-1:0] f_run;
  logic [7:0]       b_data;
  logic             b_last;
  logic [CNT_W-1:0] b_run;

  zrle_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .cmd_data (f_data),
    .cmd_last (f_last),
    .cmd_run  (f_run)
  );

  // Commands carry the byte, the stream-end flag and the run length in front of it.
  zrle_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_data, f_last, f_run}),
    .pop       (q_pop),
    .pop_data  ({b_data, b_last, b_run}),
    .full      (q_full),
    .empty     (q_empty)
  );

  zrle_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .cmd_data  (b_data),
    .cmd_last  (b_last),
    .cmd_run   (b_run),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule : zero_run_length_encoder_core

`default_nettype wire

[hw/rtl/zrle_checker.sv]
// Port-level checks for the zero run-length encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module zrle_checker
  import zrle_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result item stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The stream terminator is a zero byte and always closes the item's results.
  a_eos_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_stream |->
      out_item.last_of_run && (out_item.out_byte == BYTE_ZERO))
    else $error("malformed stream terminator");

  // Reset leaves no result item pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Inputs are only checked for being known while accepted.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_item))
    else $error("unknown input item accepted");

endmodule : zrle_checker

bind zero_run_length_encoder_core zrle_checker u_zrle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
